// ===== hw/rtl/twcm_pkg.sv =====
// Shared types and constants of the textured wall column mapper.
package twcm_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;   // ignored by the block

    // Wall faces, also the upper bits of the texel store address
    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    localparam int FACE_AW  = 12;                 // address bits per face
    localparam int STORE_AW = FACE_AW + 2;        // face and texel address
    localparam int TEXEL_W  = 24;
    localparam int QUO_W    = 25;                 // widest step quotient
    localparam int POS_W    = 40;
    localparam int STEP_W   = 23;

    localparam logic [TEXEL_W-1:0] HALF_MASK  = 24'd8355711;
    localparam logic [10:0]        SCR_H_RST  = 11'd480;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_texel;
        logic start_col;
        logic pixel_issue;
        logic div_step;
        logic load_step;
        logic mul;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/twcm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module twcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hw/rtl/twcm_ctrl.sv =====
// Controller state machine of the textured wall column mapper.
module twcm_ctrl #(
    parameter int DIV_STEPS = 23
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_req_type,
    input  twcm_pkg::t_status i_status,
    output logic              o_ready,
    output twcm_pkg::t_cmd    o_cmd
);
    import twcm_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SAT  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_PIX  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.wr_texel    = w_accept && (i_req_type == REQ_WRITE);
                o_cmd.start_col   = w_accept && (i_req_type == REQ_START);
                o_cmd.pixel_issue = w_accept && (i_req_type == REQ_PIXEL) && i_status.busy;
                if (o_cmd.start_col) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else if (o_cmd.pixel_issue) begin
                    n_state = ST_PIX;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                o_cmd.load_step = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_PIX: begin
                // hold the texel until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_pix_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pixel_issue |=> (r_state == ST_PIX))
        else $error("pixel issue did not enter the texel wait state");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_LAST) |=> (r_state == ST_SAT))
        else $error("divider did not stop after its last step");

    a_mul_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_IDLE))
        else $error("column setup did not return to idle");
endmodule

// ===== hw/rtl/twcm_datapath.sv =====
// Datapath of the textured wall column mapper: texel store, step divider, pixel shading.
module twcm_datapath #(
    parameter int TEX_SIZE = 64,
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twcm_pkg::t_cmd    i_cmd,
    output twcm_pkg::t_status o_status,
    input  logic              i_cfg_we,
    input  logic [10:0]       i_cfg_wdata,
    input  logic [1:0]        i_texel_face,
    input  logic [11:0]       i_texel_address,
    input  logic [23:0]       i_texel_value,
    input  logic              i_hit_side,
    input  logic              i_dir_x_negative,
    input  logic              i_dir_y_positive,
    input  logic [15:0]       i_wall_fraction,
    input  logic [15:0]       i_slice_height,
    input  logic [9:0]        i_first_row,
    input  logic [10:0]       i_stop_row,
    input  logic [10:0]       i_screen_column,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [9:0]        o_pixel_row,
    output logic [10:0]       o_pixel_column,
    output logic [23:0]       o_pixel_color,
    output logic              o_write_enable,
    output logic              o_last_in_column
);
    import twcm_pkg::*;

    localparam int TEX_LOG = $clog2(TEX_SIZE);
    localparam int DVD_W   = TEX_LOG + 17;
    localparam logic [DVD_W-1:0] DVD_INIT = DVD_W'(TEX_SIZE) << 16;
    localparam logic [10:0] COL_MASK = 11'(MAX_COLS - 1);

    // column setup registers
    logic [10:0]             r_screen_height;
    logic [1:0]              r_face, n_face;
    logic [TEX_LOG-1:0]      r_tex_col, n_tex_col;
    logic [10:0]             r_row;
    logic [10:0]             r_end, n_end;
    logic [10:0]             r_col;
    logic                    r_busy;
    logic signed [16:0]      r_offset;
    logic [STEP_W-1:0]       r_tex_step;
    logic [POS_W-1:0]        r_tex_pos;

    // divider
    logic [DVD_W-1:0]        r_dvd;
    logic [15:0]             r_div;
    logic [15:0]             r_rem;
    logic [QUO_W-1:0]        r_quo;
    logic [16:0]             w_sh;
    logic                    w_ge;
    logic signed [40:0]      w_prod;

    // pixel path
    logic [TEX_LOG-1:0]      w_row_tex;
    logic [FACE_AW-1:0]      w_tex_addr;
    logic [11:0]             w_row_inc;
    logic                    w_last;
    logic [9:0]              r_pend_row;
    logic                    r_pend_last;
    logic [TEXEL_W-1:0]      w_texel, w_shade;

    // output register
    logic                    r_out_valid;
    logic [9:0]              r_out_row;
    logic [10:0]             r_out_col;
    logic [TEXEL_W-1:0]      r_out_color;
    logic                    r_out_we;
    logic                    r_out_last;

    // face from wall side and ray direction; mirror the column on west and south
    always_comb begin
        if (!i_hit_side) begin
            n_face = i_dir_x_negative ? FACE_WEST : FACE_EAST;
        end else begin
            n_face = i_dir_y_positive ? FACE_SOUTH : FACE_NORTH;
        end
        n_tex_col = i_wall_fraction[15 -: TEX_LOG];
        if (n_face == FACE_WEST || n_face == FACE_SOUTH) begin
            n_tex_col = ~n_tex_col;
        end
        n_end = ({2'b0, i_stop_row} > 13'(MAX_ROWS)) ? 11'(MAX_ROWS) : i_stop_row;
    end

    assign w_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_prod = r_offset * $signed({1'b0, r_tex_step});

    assign w_row_tex  = r_tex_pos[16 +: TEX_LOG];
    assign w_tex_addr = FACE_AW'({w_row_tex, r_tex_col});
    assign w_row_inc  = {1'b0, r_row} + 12'd1;
    assign w_last     = (w_row_inc >= {1'b0, r_end});

    twcm_ram #(
        .WIDTH(TEXEL_W),
        .DEPTH(1 << STORE_AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_texel),
        .i_wr_addr({i_texel_face, i_texel_address}),
        .i_wr_data(i_texel_value),
        .i_rd_en  (i_cmd.pixel_issue),
        .i_rd_addr({r_face, w_tex_addr}),
        .o_rd_data(w_texel)
    );

    // halve each channel on north and east faces
    assign w_shade = (r_face == FACE_NORTH || r_face == FACE_EAST)
                   ? ((w_texel >> 1) & HALF_MASK) : w_texel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= SCR_H_RST;
            r_busy          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_screen_height <= i_cfg_wdata;
            end
            if (i_cmd.start_col) begin
                r_busy <= ({1'b0, i_first_row} < n_end);
            end else if (i_cmd.pixel_issue) begin
                r_busy <= !w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_col) begin
            r_face    <= n_face;
            r_tex_col <= n_tex_col;
            r_row     <= {1'b0, i_first_row};
            r_end     <= n_end;
            r_col     <= i_screen_column & COL_MASK;
            r_offset  <= $signed({7'b0, i_first_row})
                       - $signed({7'b0, r_screen_height[10:1]})
                       + $signed({2'b0, i_slice_height[15:1]});
            r_dvd     <= DVD_INIT;
            r_div     <= (i_slice_height == 16'd0) ? 16'd1 : i_slice_height;
            r_rem     <= '0;
            r_quo     <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_ge ? 16'(w_sh - {1'b0, r_div}) : w_sh[15:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
        if (i_cmd.load_step) begin
            r_tex_step <= (|r_quo[QUO_W-1:STEP_W]) ? '1 : r_quo[STEP_W-1:0];
        end
        if (i_cmd.mul) begin
            r_tex_pos <= w_prod[POS_W-1:0];
        end
        if (i_cmd.pixel_issue) begin
            r_tex_pos   <= r_tex_pos + POS_W'(r_tex_step);
            r_row       <= w_row_inc[10:0];
            r_pend_row  <= r_row[9:0];
            r_pend_last <= w_last;
        end
        if (i_cmd.out_load) begin
            r_out_row   <= r_pend_row;
            r_out_col   <= r_col;
            r_out_color <= w_shade;
            r_out_we    <= (w_shade != '0);
            r_out_last  <= r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_pixel_row      = r_out_row;
    assign o_pixel_column   = r_out_col;
    assign o_pixel_color    = r_out_color;
    assign o_write_enable   = r_out_we;
    assign o_last_in_column = r_out_last;

    a_last_ends_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pixel_issue && w_last) |=> !r_busy)
        else $error("column still busy after its last pixel");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded pixel not presented");
endmodule

// ===== hw/rtl/textured_wall_column_mapper.sv =====
// Top level of the textured wall column mapper.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | s_axis_tvalid/tready   | tdata: request fields, tuser: req_type
//  m_axis    | out       | m_axis_tvalid/tready   | tdata: pixel, tuser: write_enable,
//            |           |                        | tlast: last_in_column
//  cfg       | in        | i_cfg_we               | i_cfg_wdata: screen_height
//
// A texel write is done at its accept; a pixel tick reads the texel store at its
// accept and shades into the output register once that register is free. A column
// start runs the accept, the bit-per-cycle step divider, then the saturate and
// position-multiply steps. Reset is synchronous, active low;
// the texel store is not cleared. The output register holds its pixel while
// m_axis_tready is low; requests are taken until the next pixel needs it.
module textured_wall_column_mapper #(
    parameter int TEX_SIZE = 64,
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config register screen_height
    input  logic         i_cfg_we,
    input  logic [10:0]  i_cfg_wdata,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] texel_face, [13:2] texel_address, [37:14] texel_value, [38] hit_side,
    // [39] dir_x_negative, [40] dir_y_positive, [56:41] wall_fraction,
    // [72:57] slice_height, [82:73] first_row, [93:83] stop_row,
    // [104:94] screen_column, [111:105] zero
    input  logic [111:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]   s_axis_tuser,
    // pixel stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [9:0] pixel_row, [20:10] pixel_column, [44:21] pixel_color, [47:45] zero
    output logic [47:0]  m_axis_tdata,
    // [0] write_enable
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    import twcm_pkg::*;

    localparam int DIV_STEPS = $clog2(TEX_SIZE) + 17;

    t_cmd        w_cmd;
    t_status     w_status;
    logic [9:0]  w_pixel_row;
    logic [10:0] w_pixel_column;
    logic [23:0] w_pixel_color;

    // sequence column setup, pixel reads and output loads
    twcm_ctrl #(
        .DIV_STEPS(DIV_STEPS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_req_type(s_axis_tuser),
        .i_status  (w_status),
        .o_ready   (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    // unpack the request fields straight into the datapath
    twcm_datapath #(
        .TEX_SIZE(TEX_SIZE),
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_texel_face    (s_axis_tdata[1:0]),
        .i_texel_address (s_axis_tdata[13:2]),
        .i_texel_value   (s_axis_tdata[37:14]),
        .i_hit_side      (s_axis_tdata[38]),
        .i_dir_x_negative(s_axis_tdata[39]),
        .i_dir_y_positive(s_axis_tdata[40]),
        .i_wall_fraction (s_axis_tdata[56:41]),
        .i_slice_height  (s_axis_tdata[72:57]),
        .i_first_row     (s_axis_tdata[82:73]),
        .i_stop_row      (s_axis_tdata[93:83]),
        .i_screen_column (s_axis_tdata[104:94]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_pixel_row     (w_pixel_row),
        .o_pixel_column  (w_pixel_column),
        .o_pixel_color   (w_pixel_color),
        .o_write_enable  (m_axis_tuser),
        .o_last_in_column(m_axis_tlast)
    );

    assign m_axis_tdata = {3'b0, w_pixel_color, w_pixel_column, w_pixel_row};
endmodule
